FILE: hw/rtl/ttlf_pkg.sv
// Package: shared types, constants and the three-tap kernel for the line filter.
`timescale 1ns / 1ps
package ttlf_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned LEN_W = 13;
  localparam int unsigned POS_W = 12;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd640;
  localparam logic [LEN_W-1:0] MAX_LINE  = 13'd4096;
  localparam logic [LEN_W-1:0] LEN_ONE   = 13'd1;

  // Output queue geometry
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned FIFO_CW    = 4;
  // A new pixel may enter only if two more beats of room remain after the one in flight
  localparam logic [FIFO_CW-1:0] READY_LEVEL = 4'd4;

  // Q16 weights, already scaled by 2/sqrt(2*pi)
  localparam logic [23:0] W_OUTER  = 24'd784;
  localparam logic [23:0] W_CENTER = 24'd41832;
  localparam logic [23:0] Q16_HALF = 24'd32768;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;    // results pushed this cycle: 0, 1 or 2
    res_t       r0;   // goes out first
    res_t       r1;
  } push_t;

  function automatic logic [PIX_W-1:0] tap3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [8:0]  sum_ac;
    logic [23:0] s;
    sum_ac = {1'b0, a} + {1'b0, c};
    s = W_OUTER * {15'd0, sum_ac} + W_CENTER * {16'd0, b} + Q16_HALF;
    return s[23:16];
  endfunction

endpackage

FILE: hw/rtl/ttlf_core.sv
// Line state and kernel: takes one registered pixel per cycle while in_beat is high, emits zero to two results.
`timescale 1ns / 1ps
module ttlf_core import ttlf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_beat,     // pixel accepted this edge
  input  logic [PIX_W-1:0] in_pix,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  output push_t            push
);

  logic             stg_vld_r;
  logic [PIX_W-1:0] stg_pix_r;
  logic [LEN_W-1:0] len_r;
  logic [PIX_W-1:0] prior_r, prior_nxt;
  logic [PIX_W-1:0] center_r, center_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] pos_inc;

  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_ONE;
    end else if (len_r > MAX_LINE) begin
      eff_len = MAX_LINE;
    end else begin
      eff_len = len_r;
    end
  end

  assign pos_inc = {1'b0, pos_r} + LEN_ONE;

  always_comb begin
    push       = '0;
    prior_nxt  = prior_r;
    center_nxt = center_r;
    pos_nxt    = pos_r;
    if (stg_vld_r) begin
      if (eff_len == LEN_ONE) begin
        // single-pixel lines: both neighbors replicate the pixel itself
        push.n       = 2'd1;
        push.r0.pix  = tap3(stg_pix_r, stg_pix_r, stg_pix_r);
        push.r0.last = 1'b1;
        pos_nxt      = '0;
      end else if (pos_r == '0) begin
        prior_nxt  = stg_pix_r;
        center_nxt = stg_pix_r;
        pos_nxt    = {{(POS_W-1){1'b0}}, 1'b1};
      end else begin
        push.r0.pix  = tap3(prior_r, center_r, stg_pix_r);
        push.r0.last = 1'b0;
        prior_nxt    = center_r;
        center_nxt   = stg_pix_r;
        if (pos_inc >= eff_len) begin
          // line end: flush the last pixel with its right neighbor replicated
          push.n       = 2'd2;
          push.r1.pix  = tap3(center_r, stg_pix_r, stg_pix_r);
          push.r1.last = 1'b1;
          pos_nxt      = '0;
        end else begin
          push.n  = 2'd1;
          pos_nxt = pos_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_pix_r <= in_pix;
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      len_r     <= LEN_RESET;
      prior_r   <= '0;
      center_r  <= '0;
      pos_r     <= '0;
    end else begin
      stg_vld_r <= in_beat;
      prior_r   <= prior_nxt;
      center_r  <= center_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
        pos_r <= '0;
      end else begin
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

FILE: hw/rtl/ttlf_fifo.sv
// Output queue: takes up to two results per cycle, drains one beat per cycle while out_tready is high.
`timescale 1ns / 1ps
module ttlf_fifo import ttlf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,      // space for the in-flight pixel plus one more
  output logic  out_tvalid,
  input  logic  out_tready,
  output res_t  out_res
);

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic [FIFO_AW-1:0] wr_ptr_inc;
  logic               pop;

  assign pop        = out_tvalid && out_tready;
  assign wr_ptr_inc = wr_ptr_r + 3'd1;
  assign count_nxt  = count_r + {2'b00, push.n} - {3'b000, pop};
  assign room       = (count_r <= READY_LEVEL);
  assign out_tvalid = (count_r != '0);
  assign out_res    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_inc] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 3'd1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/three_tap_line_filter_edge_replicate.sv
// Top level of the three-tap line filter with edge replication.
// Usage:
//   in_*  : one 8-bit pixel per beat, lines back to back, no framing signal;
//           the line length comes from the cfg register (reset 640; zero acts
//           as one, values above 4096 act as 4096).
//   out_* : one filtered pixel per beat, out_tlast on the final pixel of a line.
//   cfg_* : write line_length while idle; a write also restarts the line.
// Each result needs its right neighbor, so results trail the input by one
// pixel; the last pixel of a line releases two beats, and with a line length
// of one every pixel gives one beat at once.
// Path: the beat that completes a result is held in the input register,
// then written into the output queue, whose count raises out_tvalid.
// Throughput: one pixel per cycle while in_tready is high. A line start releases nothing and a line
// end releases two, so a receiver that takes a beat every cycle keeps pace
// and in_tready stays high.
// Stall: an 8-entry output queue absorbs receiver stalls; in_tready drops
// once five results are waiting, and no beat is ever lost or repeated.
// Reset (rst_n low, synchronous): queue empty, line restarted, length 640.
`timescale 1ns / 1ps
module three_tap_line_filter_edge_replicate import ttlf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,   // [7:0] pixel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,  // [7:0] out_pixel
  output logic             out_tlast,  // line_last
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata   // [12:0] line_length
);

  push_t push;
  res_t  out_res;
  logic  room;

  assign in_tready = room;

  ttlf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_tvalid && room),
    .in_pix    (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  ttlf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.pix;
  assign out_tlast = out_res.last;

endmodule
